[hdl/svot_pkg.sv]
`default_nettype none
package svot_pkg;

	// Fixed field widths of the request
	localparam int COORD_MAX = 21;
	localparam int VEC_W = 63;
	localparam int EXT_W = 21;
	localparam int RAD_W = 20;

	// Defaults for the top-level parameters
	localparam int DEF_COORD_WIDTH = 21;
	localparam int DEF_FRACTION_BITS = 8;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Radial components are clamped to this magnitude
	localparam int SAT_W = 23;
	localparam logic signed [SAT_W-1:0] RADIAL_LIMIT = 23'sd2097153;

	// Volume type codes on the port
	localparam logic [1:0] TYPE_CYLINDER = 2'd0;
	localparam logic [1:0] TYPE_SPHERE = 2'd1;

	typedef enum logic [1:0] {
		KIND_CYL,
		KIND_SPH,
		KIND_BOX
	} kind_t;

	typedef logic signed [COORD_MAX:0] dcomp_t;
	typedef logic signed [COORD_MAX-1:0] acomp_t;

	// One classified request, coordinates sign-extended to the widest size
	typedef struct packed {
		kind_t kind;
		dcomp_t [2:0] d;
		acomp_t [2:0][2:0] ax;
		logic [2:0][EXT_W-1:0] ext;
		logic [RAD_W-1:0] prad;
		logic [RAD_W:0] radii;
	} req_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

endpackage
`default_nettype wire

[hdl/svot_front.sv]
`default_nettype none
module svot_front #(
	parameter int COORD_WIDTH = svot_pkg::DEF_COORD_WIDTH
) (
	input wire logic start,
	input wire svot_pkg::qstat_t qstat,
	input wire logic [1:0] volume_type,
	input wire logic [svot_pkg::VEC_W-1:0] volume_origin,
	input wire logic [svot_pkg::VEC_W-1:0] axis_one,
	input wire logic [svot_pkg::VEC_W-1:0] axis_two,
	input wire logic [svot_pkg::VEC_W-1:0] axis_three,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_one,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_two,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_three,
	input wire logic [svot_pkg::RAD_W-1:0] volume_radius,
	input wire logic [svot_pkg::VEC_W-1:0] probe_point,
	input wire logic [svot_pkg::RAD_W-1:0] probe_radius,
	output logic push,
	output svot_pkg::req_t req
);

	localparam int W = COORD_WIDTH;

	svot_pkg::acomp_t org [3];
	svot_pkg::acomp_t pt [3];

	// Accept whenever the queue has room
	assign push = start && !qstat.full;

	// Unpack vectors, form the offset from the volume origin, classify the type
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			org[c] = svot_pkg::acomp_t'($signed(volume_origin[c*W +: W]));
			pt[c] = svot_pkg::acomp_t'($signed(probe_point[c*W +: W]));
			req.d[c] = svot_pkg::dcomp_t'(pt[c]) - svot_pkg::dcomp_t'(org[c]);
			req.ax[0][c] = svot_pkg::acomp_t'($signed(axis_one[c*W +: W]));
			req.ax[1][c] = svot_pkg::acomp_t'($signed(axis_two[c*W +: W]));
			req.ax[2][c] = svot_pkg::acomp_t'($signed(axis_three[c*W +: W]));
		end
		req.ext[0] = extent_one;
		req.ext[1] = extent_two;
		req.ext[2] = extent_three;
		req.prad = probe_radius;
		req.radii = {1'b0, probe_radius} + {1'b0, volume_radius};
		unique case (volume_type)
			svot_pkg::TYPE_CYLINDER: req.kind = svot_pkg::KIND_CYL;
			svot_pkg::TYPE_SPHERE: req.kind = svot_pkg::KIND_SPH;
			default: req.kind = svot_pkg::KIND_BOX;
		endcase
	end

endmodule
`default_nettype wire

[hdl/svot_queue.sv]
`default_nettype none
module svot_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire svot_pkg::req_t push_req,
	input wire logic pop,
	output svot_pkg::req_t pop_req,
	output svot_pkg::qstat_t qstat
);

	localparam int D = svot_pkg::QUEUE_DEPTH;
	localparam int PW = svot_pkg::QPTR_W;
	localparam int CW = svot_pkg::QCNT_W;

	svot_pkg::req_t mem_q [D];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full = (cnt_q == CW'(D));
	assign qstat.nonempty = (cnt_q != '0);
	assign pop_req = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_req;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < CW'(D)) || pop)
		else $error("request queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("request queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(D))
		else $error("request queue count out of range");

endmodule
`default_nettype wire

[hdl/svot_back.sv]
`default_nettype none
module svot_back #(
	parameter int COORD_WIDTH = svot_pkg::DEF_COORD_WIDTH,
	parameter int FRACTION_BITS = svot_pkg::DEF_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire svot_pkg::qstat_t qstat,
	input wire svot_pkg::req_t req,
	output logic pop,
	output logic done,
	output logic overlaps
);

	localparam int W = COORD_WIDTH;
	localparam int F = FRACTION_BITS;
	localparam int EW = svot_pkg::EXT_W;
	localparam int RW0 = svot_pkg::RAD_W;
	localparam int SATW = svot_pkg::SAT_W;
	// offset, product, projection sum
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	// rounded projection, axis times projection, radial numerator
	localparam int QW = SW + 1 - F;
	localparam int MW = W + QW;
	localparam int FW = ((MW > DW + F) ? MW : DW + F) + 1;
	localparam int RW = FW + 1 - F;
	localparam int CW = ((RW > SATW) ? RW : SATW) + 1;
	// slab bounds, squared radii
	localparam int LW = ((SW > EW + 1 + F) ? SW : EW + 1 + F) + 1;
	localparam int RRW = 2 * (RW0 + 1);
	localparam int QSW = 2 * SATW + 2;
	localparam int HW = ((SW > RRW + 1) ? SW : RRW + 1) + 1;
	localparam int TW = (QSW > RRW) ? QSW : RRW;

	localparam logic signed [SW:0] HALF_P = (SW + 1)'(1) << (F - 1);
	localparam logic signed [FW:0] HALF_F = (FW + 1)'(1) << (F - 1);

	function automatic logic slab_ok(input logic signed [SW-1:0] p,
			input logic signed [EW-1:0] e, input logic [RW0-1:0] r);
		logic signed [LW-1:0] rs, lo, hi, pe;
		rs = LW'($signed({1'b0, r}));
		lo = -(rs <<< F);
		hi = (LW'(e) + rs) <<< F;
		pe = LW'(p);
		return (pe >= lo) && (pe <= hi);
	endfunction

	// Stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	// Stage 1: products
	logic signed [PW-1:0] prod_s1 [3][3];
	logic [RRW-1:0] rr_s1;
	svot_pkg::kind_t kind_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [W-1:0] ax_s1 [3];
	logic signed [EW-1:0] ext_s1 [3];
	logic [RW0-1:0] prad_s1;
	// Stage 2: projections and slabs
	logic signed [SW-1:0] p0_s2;
	logic hit_s2, cyl_ok_s2;
	svot_pkg::kind_t kind_s2;
	logic [RRW-1:0] rr_s2;
	logic signed [DW-1:0] d_s2 [3];
	logic signed [W-1:0] ax_s2 [3];
	// Stage 3: rounded projection
	logic signed [QW-1:0] pq_s3;
	logic hit_s3, cyl_ok_s3;
	svot_pkg::kind_t kind_s3;
	logic [RRW-1:0] rr_s3;
	logic signed [DW-1:0] d_s3 [3];
	logic signed [W-1:0] ax_s3 [3];
	// Stage 4: radial numerator
	logic signed [FW-1:0] full_s4 [3];
	logic hit_s4, cyl_ok_s4;
	svot_pkg::kind_t kind_s4;
	logic [RRW-1:0] rr_s4;
	// Stage 5: rounded, clamped radial vector
	logic signed [SATW-1:0] rc_s5 [3];
	logic hit_s5, cyl_ok_s5;
	svot_pkg::kind_t kind_s5;
	logic [RRW-1:0] rr_s5;
	// Stage 6: squares
	logic [2*SATW-1:0] sq_s6 [3];
	logic hit_s6, cyl_ok_s6;
	svot_pkg::kind_t kind_s6;
	logic [RRW-1:0] rr_s6;
	// Stage 7: answer
	logic hit_s7;

	logic signed [PW-1:0] opa [3][3];
	logic signed [SW-1:0] psum [3];
	logic signed [SW:0] pr;
	logic signed [MW-1:0] mp [3];
	logic signed [FW:0] fr [3];
	logic signed [CW-1:0] rce [3];
	logic [TW-1:0] sqsum;

	// The back end never stalls: take a request whenever one waits
	assign pop = qstat.nonempty;
	assign done = v_s7;
	assign overlaps = hit_s7;

	// Combinational pieces between stage registers
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int c = 0; c < 3; c++) begin
				if (req.kind == svot_pkg::KIND_SPH && a == 0) begin
					opa[a][c] = PW'($signed(req.d[c][DW-1:0]));
				end else begin
					opa[a][c] = PW'($signed(req.ax[a][c][W-1:0]));
				end
			end
			psum[a] = SW'(prod_s1[a][0]) + SW'(prod_s1[a][1]) + SW'(prod_s1[a][2]);
		end
		pr = (SW + 1)'(p0_s2) + HALF_P;
		sqsum = TW'(sq_s6[0]) + TW'(sq_s6[1]) + TW'(sq_s6[2]);
		for (int c = 0; c < 3; c++) begin
			mp[c] = MW'(ax_s3[c]) * MW'(pq_s3);
			fr[c] = (FW + 1)'(full_s4[c]) + HALF_F;
			rce[c] = CW'(RW'(fr[c] >>> F));
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		// products: axis by offset, or offset by offset for a sphere
		for (int a = 0; a < 3; a++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[a][c] <= opa[a][c] * PW'($signed(req.d[c][DW-1:0]));
			end
			d_s1[a] <= $signed(req.d[a][DW-1:0]);
			ax_s1[a] <= $signed(req.ax[0][a][W-1:0]);
			ext_s1[a] <= $signed(req.ext[a]);
		end
		rr_s1 <= RRW'(req.radii) * RRW'(req.radii);
		kind_s1 <= req.kind;
		prad_s1 <= req.prad;

		// projections, slab tests, sphere distance
		p0_s2 <= psum[0];
		cyl_ok_s2 <= slab_ok(psum[0], ext_s1[0], prad_s1);
		if (kind_s1 == svot_pkg::KIND_SPH) begin
			hit_s2 <= HW'(psum[0]) <= HW'($signed({1'b0, rr_s1}));
		end else begin
			hit_s2 <= slab_ok(psum[0], ext_s1[0], prad_s1)
				&& slab_ok(psum[1], ext_s1[1], prad_s1)
				&& slab_ok(psum[2], ext_s1[2], prad_s1);
		end
		kind_s2 <= kind_s1;
		rr_s2 <= rr_s1;
		d_s2 <= d_s1;
		ax_s2 <= ax_s1;

		// projection rounded to nearest, ties up
		pq_s3 <= QW'(pr >>> F);
		hit_s3 <= hit_s2;
		cyl_ok_s3 <= cyl_ok_s2;
		kind_s3 <= kind_s2;
		rr_s3 <= rr_s2;
		d_s3 <= d_s2;
		ax_s3 <= ax_s2;

		// radial numerator d*2^F - axis*p
		for (int c = 0; c < 3; c++) begin
			full_s4[c] <= (FW'(d_s3[c]) <<< F) - FW'(mp[c]);
		end
		hit_s4 <= hit_s3;
		cyl_ok_s4 <= cyl_ok_s3;
		kind_s4 <= kind_s3;
		rr_s4 <= rr_s3;

		// round and clamp each radial component
		for (int c = 0; c < 3; c++) begin
			if (rce[c] > CW'(svot_pkg::RADIAL_LIMIT)) begin
				rc_s5[c] <= svot_pkg::RADIAL_LIMIT;
			end else if (rce[c] < -CW'(svot_pkg::RADIAL_LIMIT)) begin
				rc_s5[c] <= -svot_pkg::RADIAL_LIMIT;
			end else begin
				rc_s5[c] <= SATW'(rce[c]);
			end
		end
		hit_s5 <= hit_s4;
		cyl_ok_s5 <= cyl_ok_s4;
		kind_s5 <= kind_s4;
		rr_s5 <= rr_s4;

		// squares
		for (int c = 0; c < 3; c++) begin
			sq_s6[c] <= (2 * SATW)'(rc_s5[c]) * (2 * SATW)'(rc_s5[c]);
		end
		hit_s6 <= hit_s5;
		cyl_ok_s6 <= cyl_ok_s5;
		kind_s6 <= kind_s5;
		rr_s6 <= rr_s5;

		// final answer
		if (kind_s6 == svot_pkg::KIND_CYL) begin
			hit_s7 <= cyl_ok_s6 && (sqsum <= TW'(rr_s6));
		end else begin
			hit_s7 <= hit_s6;
		end
	end

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped request did not enter the pipeline");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##6 done)
		else $error("result strobe missing six cycles after stage one");

endmodule
`default_nettype wire

[hdl/sphere_volume_overlap_test.sv]
`default_nettype none
// Probe sphere versus collision volume overlap test.
// Request channel: drive the volume and probe fields and raise start; the
// request is taken at a rising edge where start is high and busy is low.
// Volume type 0 is a cylinder, 1 a sphere, anything else an oriented box.
// Result channel: done pulses for one cycle with overlaps valid in that
// cycle. The receiver cannot stall; every result must be taken when shown.
// An accepted request is written into the request queue, then passes
// through the arithmetic pipeline stage registers to done and overlaps.
// Throughput: one request per cycle; the pipeline never stalls, so busy
// only rises if the two-entry request queue were full, which does not
// happen in steady operation. The rate is set by the back end, which takes
// one request from the queue in every cycle in which one waits; multipliers
// sit in stages one, four and six.
// Reset: arst_n clears the queue and all stage valids; requests in flight
// are dropped, no result is invented and no setup is needed afterwards.
module sphere_volume_overlap_test #(
	parameter int COORD_WIDTH = svot_pkg::DEF_COORD_WIDTH,
	parameter int FRACTION_BITS = svot_pkg::DEF_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] volume_type,
	input wire logic [svot_pkg::VEC_W-1:0] volume_origin,
	input wire logic [svot_pkg::VEC_W-1:0] axis_one,
	input wire logic [svot_pkg::VEC_W-1:0] axis_two,
	input wire logic [svot_pkg::VEC_W-1:0] axis_three,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_one,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_two,
	input wire logic signed [svot_pkg::EXT_W-1:0] extent_three,
	input wire logic [svot_pkg::RAD_W-1:0] volume_radius,
	input wire logic [svot_pkg::VEC_W-1:0] probe_point,
	input wire logic [svot_pkg::RAD_W-1:0] probe_radius,
	output logic done,
	output logic overlaps
);

	svot_pkg::qstat_t qstat;
	svot_pkg::req_t push_req, pop_req;
	logic push, pop;

	assign busy = qstat.full;

	svot_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.start(start),
		.qstat(qstat),
		.volume_type(volume_type),
		.volume_origin(volume_origin),
		.axis_one(axis_one),
		.axis_two(axis_two),
		.axis_three(axis_three),
		.extent_one(extent_one),
		.extent_two(extent_two),
		.extent_three(extent_three),
		.volume_radius(volume_radius),
		.probe_point(probe_point),
		.probe_radius(probe_radius),
		.push(push),
		.req(push_req)
	);

	svot_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_req(push_req),
		.pop(pop),
		.pop_req(pop_req),
		.qstat(qstat)
	);

	svot_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.req(pop_req),
		.pop(pop),
		.done(done),
		.overlaps(overlaps)
	);

endmodule
`default_nettype wire

[dv/tb_sphere_volume_overlap_test.sv]
`default_nettype none
module tb_sphere_volume_overlap_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = svot_pkg::DEF_FRACTION_BITS;
	localparam int CW = svot_pkg::DEF_COORD_WIDTH;
	localparam int VW = svot_pkg::VEC_W;
	localparam int EW = svot_pkg::EXT_W;
	localparam int RW = svot_pkg::RAD_W;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [1:0] TYPE_BOX = 2'd2;
	localparam logic [1:0] TYPE_BOX_ALT = 2'd3;
	localparam longint RAD_CLAMP = (64'sd1 <<< 21) + 1;

	typedef struct {
		logic [1:0] vtype;
		logic [VW-1:0] origin;
		logic [VW-1:0] ax [3];
		logic signed [EW-1:0] ext [3];
		logic [RW-1:0] vrad;
		logic [VW-1:0] point;
		logic [RW-1:0] prad;
	} query_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] volume_type;
	logic [VW-1:0] volume_origin, axis_one, axis_two, axis_three, probe_point;
	logic signed [EW-1:0] extent_one, extent_two, extent_three;
	logic [RW-1:0] volume_radius, probe_radius;
	logic done;
	logic overlaps;

	bit expected_overlaps [$];
	int idle_pct;
	int stall_count;
	bit failed;

	sphere_volume_overlap_test u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.volume_type(volume_type), .volume_origin(volume_origin),
		.axis_one(axis_one), .axis_two(axis_two), .axis_three(axis_three),
		.extent_one(extent_one), .extent_two(extent_two), .extent_three(extent_three),
		.volume_radius(volume_radius), .probe_point(probe_point),
		.probe_radius(probe_radius), .done(done), .overlaps(overlaps)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Vector packing helpers
	function automatic longint coord(logic [VW-1:0] v, int i);
		logic signed [CW-1:0] c;
		c = v[i*CW +: CW];
		return longint'(c);
	endfunction

	function automatic logic [VW-1:0] pack3(longint x, longint y, longint z);
		logic [VW-1:0] v;
		v = '0;
		v[0 +: CW] = x[CW-1:0];
		v[CW +: CW] = y[CW-1:0];
		v[2*CW +: CW] = z[CW-1:0];
		return v;
	endfunction

	function automatic longint round_frac(longint x);
		return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic bit in_slab(longint proj, longint ext, longint prad);
		return proj >= -(prad <<< FRAC) && proj <= ((ext + prad) <<< FRAC);
	endfunction

	// Overlap prediction, exact in 64-bit integers
	function automatic bit predict_overlap(query_t q);
		longint d [3];
		longint proj [3];
		longint radii, pq, rc, acc;
		bit hit;
		radii = longint'(q.prad) + longint'(q.vrad);
		for (int i = 0; i < 3; i++)
			d[i] = coord(q.point, i) - coord(q.origin, i);
		for (int k = 0; k < 3; k++) begin
			proj[k] = 0;
			for (int i = 0; i < 3; i++)
				proj[k] += coord(q.ax[k], i) * d[i];
		end
		if (q.vtype == svot_pkg::TYPE_CYLINDER) begin
			hit = in_slab(proj[0], longint'(q.ext[0]), longint'(q.prad));
			if (hit) begin
				pq = round_frac(proj[0]);
				acc = 0;
				for (int i = 0; i < 3; i++) begin
					rc = round_frac((d[i] <<< FRAC) - coord(q.ax[0], i) * pq);
					if (rc > RAD_CLAMP) rc = RAD_CLAMP;
					if (rc < -RAD_CLAMP) rc = -RAD_CLAMP;
					acc += rc * rc;
				end
				hit = acc <= radii * radii;
			end
		end else if (q.vtype == svot_pkg::TYPE_SPHERE) begin
			hit = d[0] * d[0] + d[1] * d[1] + d[2] * d[2] <= radii * radii;
		end else begin
			hit = 1'b1;
			for (int k = 0; k < 3; k++)
				hit &= in_slab(proj[k], longint'(q.ext[k]), longint'(q.prad));
		end
		return hit;
	endfunction

	// Request monitor, result checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			query_t q;
			if (done) begin
				if (expected_overlaps.size() == 0) begin
					$display("%0t unexpected result: expected none actual %0b",
						$time, overlaps);
					failed = 1'b1;
				end else begin
					if (overlaps !== expected_overlaps[0]) begin
						$display("%0t overlaps mismatch: expected %0b actual %0b",
							$time, expected_overlaps[0], overlaps);
						failed = 1'b1;
					end
					void'(expected_overlaps.pop_front());
				end
			end
			if (start && !busy) begin
				q.vtype = volume_type;
				q.origin = volume_origin;
				q.ax[0] = axis_one;
				q.ax[1] = axis_two;
				q.ax[2] = axis_three;
				q.ext[0] = extent_one;
				q.ext[1] = extent_two;
				q.ext[2] = extent_three;
				q.vrad = volume_radius;
				q.point = probe_point;
				q.prad = probe_radius;
				expected_overlaps.push_back(predict_overlap(q));
			end
			if (done || (start && !busy))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= IDLE_LIMIT) begin
				$display("FAIL sphere_volume_overlap_test");
				$finish;
			end
		end
	end

	// Send one request, with random idle cycles ahead of it
	task automatic send_query(query_t q);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		volume_type <= q.vtype;
		volume_origin <= q.origin;
		axis_one <= q.ax[0];
		axis_two <= q.ax[1];
		axis_three <= q.ax[2];
		extent_one <= q.ext[0];
		extent_two <= q.ext[1];
		extent_three <= q.ext[2];
		volume_radius <= q.vrad;
		probe_point <= q.point;
		probe_radius <= q.prad;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_overlaps.size() != 0)
			@(posedge clk);
	endtask

	function automatic longint rand_span(int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [VW-1:0] rand_raw();
		return VW'({$urandom, $urandom});
	endfunction

	// Well-formed query: probe near the volume, moderate axes and sizes
	function automatic query_t rand_near_query();
		query_t q;
		int span;
		span = ($urandom_range(3) == 0) ? 60000 : 2000;
		q.vtype = 2'($urandom_range(3));
		q.origin = pack3(rand_span(900000), rand_span(900000), rand_span(900000));
		q.point = pack3(coord(q.origin, 0) + rand_span(span),
			coord(q.origin, 1) + rand_span(span), coord(q.origin, 2) + rand_span(span));
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(1))
				q.ax[k] = pack3(k == 0 ? 256 : 0, k == 1 ? 256 : 0, k == 2 ? 256 : 0);
			else
				q.ax[k] = pack3(rand_span(300), rand_span(300), rand_span(300));
			q.ext[k] = ($urandom_range(9) == 0) ? EW'(-longint'($urandom_range(span)))
				: EW'($urandom_range(2 * span));
		end
		q.vrad = RW'($urandom_range(span));
		q.prad = RW'($urandom_range(span));
		return q;
	endfunction

	function automatic query_t rand_noise_query();
		query_t q;
		q.vtype = 2'($urandom_range(3));
		q.origin = rand_raw();
		q.point = rand_raw();
		for (int k = 0; k < 3; k++) begin
			q.ax[k] = rand_raw();
			q.ext[k] = EW'($urandom);
		end
		q.vrad = RW'($urandom);
		q.prad = RW'($urandom);
		return q;
	endfunction

	function automatic query_t base_query(logic [1:0] vtype);
		query_t q;
		q.vtype = vtype;
		q.origin = pack3(0, 0, 0);
		q.point = pack3(0, 0, 0);
		q.ax[0] = pack3(256, 0, 0);
		q.ax[1] = pack3(0, 256, 0);
		q.ax[2] = pack3(0, 0, 256);
		q.ext[0] = EW'(1000);
		q.ext[1] = EW'(1000);
		q.ext[2] = EW'(1000);
		q.vrad = RW'(100);
		q.prad = RW'(50);
		return q;
	endfunction

	// Boundaries, every volume type and the corner cases
	task automatic test_directed();
		query_t q;
		q = base_query(svot_pkg::TYPE_SPHERE);
		q.point = pack3(90, 120, 0);
		send_query(q);
		q.point = pack3(90, 121, 0);
		send_query(q);
		q.vrad = '1;
		q.prad = '1;
		q.origin = pack3(-1048576, -1048576, -1048576);
		q.point = pack3(1048575, 1048575, 1048575);
		send_query(q);
		q.origin = '1;
		send_query(q);
		// slab edges on the cylinder axis
		q = base_query(svot_pkg::TYPE_CYLINDER);
		q.point = pack3(-50, 0, 0);
		send_query(q);
		q.point = pack3(-51, 0, 0);
		send_query(q);
		q.point = pack3(1050, 0, 0);
		send_query(q);
		q.point = pack3(1051, 0, 0);
		send_query(q);
		q.point = pack3(500, 150, 0);
		send_query(q);
		q.point = pack3(500, 151, 0);
		send_query(q);
		q.ax[0] = pack3(181, 181, 1);
		q.point = pack3(300, -200, 77);
		send_query(q);
		q.ax[0] = pack3(-1048576, 1048575, -1048576);
		q.point = pack3(-1048576, 1048575, 3);
		q.ext[0] = EW'(1048575);
		q.prad = '1;
		q.vrad = '1;
		send_query(q);
		// box edges, negative extent, type three, non-unit axes
		q = base_query(TYPE_BOX);
		q.point = pack3(1050, -50, 1050);
		send_query(q);
		q.point = pack3(1050, -51, 1050);
		send_query(q);
		q.ext[1] = EW'(-200);
		q.point = pack3(0, -120, 0);
		send_query(q);
		q.ext[1] = EW'(-1048576);
		send_query(q);
		q = base_query(TYPE_BOX_ALT);
		q.point = pack3(500, 500, 500);
		send_query(q);
		q.ax[2] = pack3(512, -3, 7);
		q.point = pack3(500, 500, 1030);
		send_query(q);
		q = rand_noise_query();
		q.vtype = TYPE_BOX;
		q.ext[0] = EW'(1048575);
		q.ext[1] = EW'(1048575);
		q.ext[2] = EW'(1048575);
		q.prad = '1;
		send_query(q);
	endtask

	task automatic test_random(int count, int pct);
		idle_pct = pct;
		for (int n = 0; n < count; n++)
			send_query(($urandom_range(9) < 8) ? rand_near_query() : rand_noise_query());
	endtask

	task automatic test_pause_until_drained();
		idle_pct = 0;
		for (int n = 0; n < 10; n++)
			send_query(rand_near_query());
		wait_drained();
		for (int n = 0; n < 10; n++)
			send_query(rand_near_query());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		volume_type = '0;
		volume_origin = '0;
		axis_one = '0;
		axis_two = '0;
		axis_three = '0;
		extent_one = '0;
		extent_two = '0;
		extent_three = '0;
		volume_radius = '0;
		probe_point = '0;
		probe_radius = '0;
		idle_pct = 0;
		stall_count = 0;
		failed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(540, 7);
		test_random(540, 61);
		test_pause_until_drained();
		test_random(530, 0);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed)
			$display("PASS sphere_volume_overlap_test");
		else
			$display("FAIL sphere_volume_overlap_test");
		$finish;
	end

endmodule
`default_nettype wire

[sphere_volume_overlap_test.f]
hdl/svot_pkg.sv
hdl/svot_front.sv
hdl/svot_queue.sv
hdl/svot_back.sv
hdl/sphere_volume_overlap_test.sv
dv/tb_sphere_volume_overlap_test.sv
